>>> hdl/irpr_pkg.sv
// ----------------------------------------------------------------------------
// irpr_pkg
// shared codes and types of the infrared record / replay engine
// ----------------------------------------------------------------------------
`default_nettype none

package irpr_pkg;

  localparam int STATUS_W = 3;
  localparam int PHASE_W  = 2;
  localparam int COUNT_W  = 17;
  localparam int FILL_W   = 11;
  localparam int TMO_W    = 16;

  // run status codes
  localparam logic [STATUS_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REC  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PLAY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OK   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FAIL = 3'd4;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_FIRST = 2'd0;
  localparam logic [PHASE_W-1:0] PH_MARK  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SPACE = 2'd2;

  // configuration register indexes
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd10000;
  localparam logic [7:0]       LONG_MARKER   = 8'hff;
  localparam logic [15:0]      SHORT_MAX     = 16'd254;

  // one result of the engine
  typedef struct packed {
    logic [FILL_W-1:0]   fill;
    logic                carrier;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/irpr_engine.sv
// ----------------------------------------------------------------------------
// irpr_engine
// run store, record / replay sequencer and engine state
// ----------------------------------------------------------------------------
`default_nettype none

module irpr_engine #(
  parameter int BUFFER_BYTES = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      mode,
  input  wire logic [irpr_pkg::TMO_W-1:0] timeout,
  input  wire logic                      in_go,
  input  wire logic                      in_op,
  input  wire logic                      in_sensor,
  output logic                           idle,
  output logic                           res_valid,
  output irpr_pkg::res_t                 res
);

  import irpr_pkg::*;

  localparam int POS_W  = $clog2(BUFFER_BYTES + 1);
  localparam int ADDR_W = $clog2(BUFFER_BYTES);

  localparam logic [POS_W:0]   BUF_END  = (POS_W+1)'(BUFFER_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WR1, S_WR2, S_RD0, S_RD1, S_RD2
  } state_t;

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [15:0]         wval_r, wval_nxt;

  logic [7:0]          mem [BUFFER_BYTES];
  logic [7:0]          rdata_r;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [7:0]          wdata;
  logic [ADDR_W-1:0]   raddr;

  logic                lit;
  logic                is_mark;
  logic [POS_W:0]      pos_ext;
  logic                full1;
  logic                full3;
  logic [COUNT_W-1:0]  count_inc;
  logic                done;
  logic                fin;
  logic [15:0]         fin_val;
  logic [FILL_W+POS_W-1:0] fill_wide;

  assign lit       = ~in_sensor;
  assign is_mark   = (phase_r == PH_MARK);
  assign pos_ext   = {1'b0, pos_r};
  assign full1     = (pos_ext >= BUF_END);
  assign full3     = ((pos_ext + (POS_W+1)'(2)) >= BUF_END);
  assign count_inc = count_r + COUNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    wval_nxt   = wval_r;
    we         = 1'b0;
    waddr      = pos_r[ADDR_W-1:0];
    wdata      = 8'h00;
    raddr      = pos_r[ADDR_W-1:0];
    done       = 1'b0;
    fin        = 1'b0;
    fin_val    = 16'h0000;

    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        if (pos_r == POS_LAST) begin
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_r + POS_ONE;
        end
      end

      S_IDLE: begin
        if (in_go) begin
          if (in_op) begin
            pos_nxt = '0;
            if (!mode) begin
              status_nxt = ST_REC;
              phase_nxt  = PH_FIRST;
              count_nxt  = '0;
              done       = 1'b1;
            end else begin
              // fetch the first run from the head of the store
              status_nxt = ST_PLAY;
              phase_nxt  = PH_MARK;
              raddr      = '0;
              pos_nxt    = POS_ONE;
              state_nxt  = S_RD0;
            end
          end else if (status_r == ST_REC) begin
            if (phase_r == PH_FIRST) begin
              if (lit) begin
                phase_nxt = PH_MARK;
                count_nxt = COUNT_W'(1);
              end
              done = 1'b1;
            end else if (is_mark != lit) begin
              // run change: store the finished run
              phase_nxt = is_mark ? PH_SPACE : PH_MARK;
              count_nxt = COUNT_W'(1);
              if (count_r[15:0] <= SHORT_MAX) begin
                if (full1) begin
                  status_nxt = ST_FAIL;
                end else begin
                  we      = 1'b1;
                  wdata   = count_r[7:0];
                  pos_nxt = pos_r + POS_ONE;
                end
                done = 1'b1;
              end else if (full3) begin
                status_nxt = ST_FAIL;
                done       = 1'b1;
              end else begin
                we        = 1'b1;
                wdata     = LONG_MARKER;
                pos_nxt   = pos_r + POS_ONE;
                wval_nxt  = count_r[15:0];
                state_nxt = S_WR1;
              end
            end else begin
              count_nxt = count_inc;
              if (count_inc > {1'b0, timeout}) begin
                if (lit || full1) begin
                  status_nxt = ST_FAIL;
                end else begin
                  // end mark
                  we         = 1'b1;
                  pos_nxt    = pos_r + POS_ONE;
                  status_nxt = ST_OK;
                end
              end
              done = 1'b1;
            end
          end else if (status_r == ST_PLAY) begin
            if (count_r > COUNT_W'(1)) begin
              count_nxt = count_r - COUNT_W'(1);
              done      = 1'b1;
            end else begin
              phase_nxt = is_mark ? PH_SPACE : PH_MARK;
              if (full1) begin
                count_nxt  = '0;
                phase_nxt  = PH_SPACE;
                status_nxt = ST_FAIL;
                done       = 1'b1;
              end else begin
                pos_nxt   = pos_r + POS_ONE;
                state_nxt = S_RD0;
              end
            end
          end else begin
            done = 1'b1;
          end
        end
      end

      S_WR1: begin
        we        = 1'b1;
        wdata     = wval_r[15:8];
        pos_nxt   = pos_r + POS_ONE;
        state_nxt = S_WR2;
      end

      S_WR2: begin
        we        = 1'b1;
        wdata     = wval_r[7:0];
        pos_nxt   = pos_r + POS_ONE;
        state_nxt = S_IDLE;
        done      = 1'b1;
      end

      S_RD0: begin
        if (rdata_r == LONG_MARKER) begin
          // truncated long code fails with the marker consumed
          if ((pos_ext + (POS_W+1)'(1)) >= BUF_END) begin
            count_nxt  = '0;
            phase_nxt  = PH_SPACE;
            status_nxt = ST_FAIL;
            state_nxt  = S_IDLE;
            done       = 1'b1;
          end else begin
            pos_nxt   = pos_r + POS_ONE;
            state_nxt = S_RD1;
          end
        end else begin
          fin     = 1'b1;
          fin_val = {8'h00, rdata_r};
        end
      end

      S_RD1: begin
        wval_nxt  = {rdata_r, wval_r[7:0]};
        pos_nxt   = pos_r + POS_ONE;
        state_nxt = S_RD2;
      end

      S_RD2: begin
        fin     = 1'b1;
        fin_val = {wval_r[15:8], rdata_r};
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a fetched run ends the replay when zero, else it starts counting
    if (fin) begin
      state_nxt = S_IDLE;
      done      = 1'b1;
      if (fin_val == 16'h0000) begin
        count_nxt  = '0;
        phase_nxt  = PH_SPACE;
        status_nxt = ST_OK;
      end else begin
        count_nxt = COUNT_W'(fin_val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      status_r <= ST_IDLE;
      phase_r  <= PH_FIRST;
      count_r  <= '0;
      pos_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wval_r <= wval_nxt;
  end

  // run store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign fill_wide   = {{FILL_W{1'b0}}, pos_nxt};
  assign idle        = (state_r == S_IDLE);
  assign res_valid   = done;
  assign res.status  = status_nxt;
  assign res.carrier = (status_nxt == ST_PLAY) && (phase_nxt == PH_MARK);
  assign res.fill    = fill_wide[FILL_W-1:0];

endmodule

`default_nettype wire

>>> hdl/ir_pulse_record_replay.sv
// ----------------------------------------------------------------------------
// ir_pulse_record_replay
// infrared learn-and-replay engine: records mark / space run lengths into a
// byte store on timer ticks and plays them back as a carrier enable
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  in_     | in  | in_tvalid/in_tready | tuser: op, tdata: sensor_pin
//  out_    | out | out_tvalid/tready   | tdata: status, carrier_on, fill
//  cfg_    | in  | cfg_we              | cfg_addr: index, cfg_wdata: value
//
// a tick that touches no store byte and a short run write end in the idle
// state; a long run write adds the two length bytes in S_WR1 and S_WR2, a
// run read waits for the registered byte in S_RD0 and a long one goes on
// through S_RD1 and S_RD2; the single port pair of the run store sets these
// steps; after reset a clearing pass zeroes the store and holds in_tready low
// a result waits in the output register; the next request is taken while it
// waits as long as it is taken by out_tready in the same cycle, so a stall
// on the output side stops input after one request
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_record_replay #(
  parameter int BUFFER_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input request
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] sensor_pin, [7:1] zero
  input  wire logic        in_tuser,   // [0] op
  // result
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [2:0] status, [3] carrier_on,
                                       // [14:4] buffer_fill, [15] zero
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  import irpr_pkg::*;

  logic             mode_r;
  logic [TMO_W-1:0] timeout_r;

  logic             eng_idle;
  logic             in_go;
  logic             res_valid;
  res_t             res;

  logic             out_valid_r;
  logic [15:0]      out_data_r;

  // configuration registers; the user writes them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:    mode_r    <= cfg_wdata[0];
        REG_TIMEOUT: timeout_r <= cfg_wdata[TMO_W-1:0];
        default:     mode_r    <= mode_r;
      endcase
    end
  end

  // take a request when the engine is free and the result slot drains
  assign in_tready = eng_idle && (!out_valid_r || out_tready);
  assign in_go     = in_tvalid && in_tready;

  irpr_engine #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .timeout   (timeout_r),
    .in_go     (in_go),
    .in_op     (in_tuser),
    .in_sensor (in_tdata[0]),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= {1'b0, res.fill, res.carrier, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> bench/ir_pulse_record_replay_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_record_replay_tb
// self-checking bench for the infrared record / replay engine: a local
// tracker of runs, store and status predicts every result, which is
// compared field by field; directed cases, random record and replay takes
// with noise, random gaps and output stalls, then three-byte codes
// ----------------------------------------------------------------------------

module ir_pulse_record_replay_tb;

  import irpr_pkg::*;

  localparam int RUN_BYTES      = 1024;
  localparam int IDX_W          = $clog2(RUN_BYTES);
  localparam int SETTLE_CYCLES  = 8;     // covers the longest store access
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 4000;  // clearing pass plus slack

  // request opcodes and sensor levels (sensor is active low)
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_START    = 1'b1;
  localparam logic PIN_LIT     = 1'b0;
  localparam logic PIN_DARK    = 1'b1;
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_REPLAY = 1'b1;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;  // [0] sensor_pin, [7:1] zero
  logic        in_tuser   = 1'b0;  // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [2:0] status, [3] carrier_on,
                                   // [14:4] buffer_fill, [15] zero
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = 1'b0;
  logic [15:0] cfg_wdata  = 16'd0;

  // pacing knobs, flipped per phase
  bit pace_on  = 1'b0;
  bit stall_on = 1'b0;

  int err_cnt      = 0;
  int busy_items   = 0;  // requests that start or advance an operation
  int out_hold     = 0;
  int quiet_cycles = 0;

  res_t ir_results[$];  // expected results, oldest first

  // tracked engine state
  logic [STATUS_W-1:0] eng_status  = ST_IDLE;
  logic [PHASE_W-1:0]  eng_phase   = PH_FIRST;
  logic [COUNT_W-1:0]  eng_count   = '0;
  int unsigned         eng_pos     = 0;
  logic [7:0]          eng_bytes [RUN_BYTES] = '{default: 8'h00};
  logic                eng_mode    = MODE_RECORD;
  logic [TMO_W-1:0]    eng_timeout = TIMEOUT_RESET;

  ir_pulse_record_replay #(.BUFFER_BYTES(RUN_BYTES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // run store tracking
  // --------------------------------------------------------------------------

  // append one run: one byte up to the short limit, else marker + 2 bytes
  function automatic logic store_run(logic [15:0] len);
    if (len <= SHORT_MAX) begin
      if (eng_pos >= RUN_BYTES) return 1'b0;
      eng_bytes[IDX_W'(eng_pos)] = len[7:0];
      eng_pos++;
    end else begin
      if (eng_pos + 2 >= RUN_BYTES) return 1'b0;
      eng_bytes[IDX_W'(eng_pos)]     = LONG_MARKER;
      eng_bytes[IDX_W'(eng_pos + 1)] = len[15:8];
      eng_bytes[IDX_W'(eng_pos + 2)] = len[7:0];
      eng_pos += 3;
    end
    return 1'b1;
  endfunction

  // fetch the next run for replay; a zero run or running dry ends it
  function automatic void load_next_run();
    logic [7:0]  code;
    logic [16:0] run;
    logic        got;
    run = '0;
    got = 1'b0;
    if (eng_pos < RUN_BYTES) begin
      code = eng_bytes[IDX_W'(eng_pos)];
      eng_pos++;
      if (code != LONG_MARKER) begin
        run = {9'd0, code};
        got = 1'b1;
      end else if (eng_pos + 1 < RUN_BYTES) begin
        run = {1'b0, eng_bytes[IDX_W'(eng_pos)], eng_bytes[IDX_W'(eng_pos + 1)]};
        eng_pos += 2;
        got = 1'b1;
      end
      // truncated long code: marker consumed, position stays past it
    end
    if (!got) begin
      eng_count  = '0;
      eng_phase  = PH_SPACE;
      eng_status = ST_FAIL;
    end else if (run == 0) begin
      eng_count  = '0;
      eng_phase  = PH_SPACE;
      eng_status = ST_OK;
    end else begin
      eng_count = run;
    end
  endfunction

  // advance the tracked engine by one request and form its result
  function automatic res_t predict_result(logic op, logic pin);
    logic lit;
    res_t r;
    lit = (pin == PIN_LIT);
    if (op == OP_START) begin
      // start always restarts at byte 0, abandoning any running operation
      eng_pos = 0;
      if (eng_mode == MODE_RECORD) begin
        eng_status = ST_REC;
        eng_phase  = PH_FIRST;
        eng_count  = '0;
      end else begin
        eng_status = ST_PLAY;
        eng_phase  = PH_MARK;
        load_next_run();
      end
    end else if (eng_status == ST_REC) begin
      if (eng_phase == PH_FIRST) begin
        if (lit) begin
          eng_phase = PH_MARK;
          eng_count = COUNT_W'(1);
        end
      end else if ((eng_phase == PH_MARK) != lit) begin
        // level changed: the finished run goes to the store
        if (!store_run(eng_count[15:0])) eng_status = ST_FAIL;
        eng_phase = (eng_phase == PH_MARK) ? PH_SPACE : PH_MARK;
        eng_count = COUNT_W'(1);
      end else begin
        eng_count = eng_count + 1'b1;
        if (eng_count > eng_timeout) begin
          // long space closes the take, long mark means a stuck sensor
          if (lit) eng_status = ST_FAIL;
          else eng_status = store_run(16'd0) ? ST_OK : ST_FAIL;
        end
      end
    end else if (eng_status == ST_PLAY) begin
      if (eng_count > 1) begin
        eng_count = eng_count - 1'b1;
      end else begin
        eng_phase = (eng_phase == PH_MARK) ? PH_SPACE : PH_MARK;
        load_next_run();
      end
    end
    r.status  = eng_status;
    r.carrier = (eng_status == ST_PLAY) && (eng_phase == PH_MARK);
    r.fill    = FILL_W'(eng_pos);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one request; valid stays up afterwards so back-to-back requests
  // need no extra assignment in the same step
  task automatic send_req(logic op, logic pin);
    int gap;
    gap = pace_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, pin};
    do @(posedge clk); while (!in_tready);
    if (op == OP_START || eng_status == ST_REC || eng_status == ST_PLAY) busy_items++;
    ir_results.push_back(predict_result(op, pin));
  endtask

  task automatic hold_level(logic pin, int n);
    repeat (n) send_req(OP_TICK, pin);
  endtask

  // register write, only once every result is back and the store is quiet
  task automatic write_reg(logic idx, logic [15:0] val);
    in_tvalid <= 1'b0;
    wait (ir_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) eng_mode = val[0];
    else eng_timeout = val;
  endtask

  // replay until the engine leaves the replaying status, optionally
  // restarting it once along the way
  task automatic replay_all(int restart_odds);
    int restarts_left;
    restarts_left = (restart_odds > 0) ? 1 : 0;
    write_reg(REG_MODE, 16'(MODE_REPLAY));
    send_req(OP_START, 1'($urandom_range(0, 1)));
    while (eng_status == ST_PLAY) begin
      if (restarts_left > 0 && $urandom_range(1, restart_odds) == 1) begin
        restarts_left--;
        send_req(OP_START, 1'($urandom_range(0, 1)));
      end else begin
        send_req(OP_TICK, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // short directed pass over every op and the corner cases
  task automatic test_basics();
    // ticks while idle change nothing
    send_req(OP_TICK, PIN_LIT);
    send_req(OP_TICK, PIN_DARK);
    // replay of a never-recorded store hits a leading zero
    write_reg(REG_MODE, 16'(MODE_REPLAY));
    send_req(OP_START, PIN_LIT);
    // record with the reset timeout, then abandon by a fresh start
    write_reg(REG_MODE, 16'(MODE_RECORD));
    send_req(OP_START, PIN_DARK);
    send_req(OP_TICK, PIN_DARK);
    send_req(OP_TICK, PIN_LIT);
    send_req(OP_TICK, PIN_LIT);
    send_req(OP_TICK, PIN_DARK);
    send_req(OP_START, PIN_LIT);
    // replay the stale mark of 2, then the cleared zero; tick after success
    write_reg(REG_MODE, 16'(MODE_REPLAY));
    send_req(OP_START, PIN_DARK);
    hold_level(PIN_LIT, 3);
    // shortest timeout: mark 1, space times out on its second tick
    write_reg(REG_TIMEOUT, 16'd1);
    write_reg(REG_MODE, 16'(MODE_RECORD));
    send_req(OP_START, PIN_DARK);
    send_req(OP_TICK, PIN_LIT);
    hold_level(PIN_DARK, 2);
    write_reg(REG_MODE, 16'(MODE_REPLAY));
    send_req(OP_START, PIN_LIT);
    send_req(OP_TICK, PIN_DARK);
    // zero timeout: a mark fails on its second tick, later ticks ignored
    write_reg(REG_TIMEOUT, 16'd0);
    write_reg(REG_MODE, 16'(MODE_RECORD));
    send_req(OP_START, PIN_DARK);
    hold_level(PIN_LIT, 3);
  endtask

  // one-byte and three-byte codes on either side of the short limit
  task automatic test_long_codes();
    pace_on  = 1'b1;
    stall_on = 1'b1;
    write_reg(REG_TIMEOUT, 16'd255);
    write_reg(REG_MODE, 16'(MODE_RECORD));
    send_req(OP_START, PIN_DARK);
    hold_level(PIN_DARK, 1);
    hold_level(PIN_LIT, 254);
    hold_level(PIN_DARK, 255);
    send_req(OP_TICK, PIN_LIT);
    // shortest timeout closes the take on the second space tick
    write_reg(REG_TIMEOUT, 16'd1);
    hold_level(PIN_DARK, 2);
    replay_all(0);
  endtask

  // one record take with random runs, then its replay
  task automatic random_take();
    int   tmo;
    int   runs;
    int   len;
    int   pick;
    logic lvl;
    tmo = $urandom_range(1, 30);
    write_reg(REG_TIMEOUT, tmo[15:0]);
    write_reg(REG_MODE, 16'(MODE_RECORD));
    send_req(OP_START, 1'($urandom_range(0, 1)));
    hold_level(PIN_DARK, $urandom_range(0, 3));
    lvl  = PIN_LIT;
    runs = 0;
    while (eng_status == ST_REC) begin
      pick = $urandom_range(0, 19);
      runs++;
      if (runs > 40) begin
        // force the take to close with a long space
        hold_level(PIN_LIT, 1);
        hold_level(PIN_DARK, tmo + 1);
      end else if (pick == 0) begin
        // broken take: restart in the middle
        send_req(OP_START, 1'($urandom_range(0, 1)));
        lvl = PIN_LIT;
      end else begin
        if (pick == 1) len = tmo + 1;
        else if (pick == 3) len = tmo;
        else len = $urandom_range(1, (tmo < 12) ? tmo : 12);
        hold_level(lvl, len);
        lvl = ~lvl;
      end
    end
    replay_all(60);
  endtask

  // unstructured requests in either mode
  task automatic noise_burst();
    write_reg(REG_TIMEOUT, 16'($urandom_range(1, 20)));
    write_reg(REG_MODE, 16'($urandom_range(0, 1)));
    repeat ($urandom_range(10, 30))
      send_req(($urandom_range(0, 7) == 0) ? OP_START : OP_TICK,
               1'($urandom_range(0, 1)));
  endtask

  task automatic test_random(int target);
    int base;
    base = busy_items;
    while (busy_items - base < target) begin
      pace_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) noise_burst();
      else random_take();
    end
  endtask

  // --------------------------------------------------------------------------
  // result checking and output stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[14:0]);
      if (ir_results.size() == 0) begin
        $error("result with no request pending: %h", out_tdata);
        err_cnt++;
      end else begin
        want = ir_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          err_cnt++;
        end
        if (got.carrier !== want.carrier) begin
          $error("carrier_on: expected %0d, actual %0d", want.carrier, got.carrier);
          err_cnt++;
        end
        if (got.fill !== want.fill) begin
          $error("buffer_fill: expected %0d, actual %0d", want.fill, got.fill);
          err_cnt++;
        end
      end
      out_hold = stall_on ? $urandom_range(0, 5) : 0;
    end else if (out_hold > 0) begin
      out_hold--;
    end
    out_tready <= (out_hold == 0);
  end

  // watchdog: cycles with no request, no result and no register write
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // in_tready stays low through the clearing pass
    test_basics();
    test_random(350);
    test_long_codes();
    in_tvalid <= 1'b0;
    wait (ir_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
